[rtl/core/bfba_pkg.sv]
// Shared constants and types for the best-fit block allocator.
package bfba_pkg;
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ADDR_BITS_DEF = 20;
  localparam int SZ_W = 21;
  localparam int HDR_W = 7;
  localparam int KIND_W = 2;

  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_RESIZE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic REG_ARENA = 1'b0;
  localparam logic REG_HEADER = 1'b1;
endpackage

[rtl/core/bfba_table.sv]
// Block table memory: one synchronous read port, one write port.
module bfba_table import bfba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int SW = $clog2(MAX_BLOCKS + 1),
  localparam int IW = $clog2(MAX_BLOCKS),
  localparam int EW = ADDR_BITS + SZ_W + 2 * SW
) (
  input  logic clk,
  input  logic [IW-1:0] rd_idx,
  output logic [EW-1:0] rd_data,
  input  logic we,
  input  logic [IW-1:0] wr_idx,
  input  logic [EW-1:0] wr_data
);
  logic [EW-1:0] mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end
endmodule

[rtl/core/best_fit_block_allocator.sv]
// Top level of the best-fit block allocator: sequencer around the block table.
// Restart writes slot zero; allocate walks the listed blocks for the best fit and may split it;
// release matches the address over every slot, then merges free neighbors; resize reads
// the old size, then does an allocate and a release.
// One word in flight at a time; the single table read port sets the pace.
// Sync active-high reset clears control state and slot flags (slot zero stays in use); table data waits for restart.
module best_fit_block_allocator import bfba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata: request_bytes[20:0], block_address[40:21], zero fill
  input  logic [((SZ_W + ADDR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // tuser: kind[1:0]
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: address[19:0], copy_bytes[40:20], status[42:41], zero fill
  output logic [((ADDR_BITS + SZ_W + 2 + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [SZ_W-1:0] cfg_data
);
  localparam int SW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int AW = ADDR_BITS;
  localparam int EW = AW + SZ_W + 2 * SW;
  localparam int OW = ((AW + SZ_W + 2 + 7) / 8) * 8;
  localparam int CW = (AW + 1 > SZ_W) ? AW + 1 : SZ_W;
  localparam logic [SW-1:0] NIL = SW'(MAX_BLOCKS);
  localparam logic [AW:0] LIMIT = (AW + 1)'(1) << AW;

  // states
  localparam logic [3:0] S_IDLE = 4'd0, S_FIND = 4'd1, S_FINDW = 4'd2,
    S_SCAN = 4'd3, S_SCANW = 4'd4, S_GRANT = 4'd5, S_GRANTW = 4'd6,
    S_SPLIT = 4'd7, S_NXW = 4'd8, S_REL = 4'd9, S_RELW = 4'd10,
    S_MERGE = 4'd11, S_MWR = 4'd12, S_OUT = 4'd13, S_LNK = 4'd14;

  logic [3:0] state;
  logic [SZ_W-1:0] arena_bytes;
  logic [HDR_W-1:0] header_bytes, hdr_live;
  logic [MAX_BLOCKS-1:0] in_use, is_free;
  logic [SW-1:0] first_slot;
  logic built;               // links in the table are valid after the first restart

  logic [1:0] kind;
  logic [SZ_W-1:0] size;
  logic [AW-1:0] baddr;
  logic [AW-1:0] r_addr;
  logic [SZ_W-1:0] r_copy;
  logic [1:0] r_status;

  logic [IW-1:0] rd_idx, wr_idx;
  logic [EW-1:0] rd_data, wr_data;
  logic we;

  bfba_table #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_table (
    .clk, .rd_idx, .rd_data, .we, .wr_idx, .wr_data
  );

  // entry fields: {prev, next, payload, offset}
  logic [AW-1:0] e_off;
  logic [SZ_W-1:0] e_pay;
  logic [SW-1:0] e_nx, e_pv;
  assign {e_pv, e_nx, e_pay, e_off} = rd_data;

  // scan / work registers
  logic [SW-1:0] cur;        // scan index (counter)
  logic [SW-1:0] hit;        // matched or best slot
  logic [SZ_W-1:0] best_pay;
  logic [AW-1:0] best_off;
  logic [SW-1:0] best_nx;
  logic [SW-1:0] best_pv;
  logic [SZ_W-1:0] old_pay;
  logic [SW-1:0] rel_slot;   // slot being released/merged
  logic [AW-1:0] rel_off;
  logic [SZ_W-1:0] rel_pay;
  logic [SW-1:0] rel_nx, rel_pv;
  logic [SW-1:0] other;      // neighbor being merged
  logic mdir;                // 1: merging next into rel, 0: rel into prev
  logic [1:0] step;          // sub-step counter for multi-write sequences
  logic [SW-1:0] fsl;        // free slot for split
  logic [SZ_W+1:0] req;

  assign req = (SZ_W + 2)'(size) + (SZ_W + 2)'(hdr_live);

  // lowest unused slot, priority search across flags
  logic [SW-1:0] free_slot;
  always_comb begin
    free_slot = NIL;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!in_use[i]) free_slot = SW'(i);
    end
  end

  logic [AW:0] arena_clip;
  assign arena_clip = (CW'(arena_bytes) > CW'(LIMIT)) ? LIMIT : (AW + 1)'(arena_bytes);

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign m_tdata = OW'({r_status, r_copy, r_addr});

  logic [AW:0] cmp_addr;
  assign cmp_addr = (AW + 1)'(e_off) + (AW + 1)'(hdr_live);

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      arena_bytes <= SZ_W'(65536);
      header_bytes <= HDR_W'(40);
      hdr_live <= HDR_W'(40);
      in_use <= MAX_BLOCKS'(1);
      is_free <= '0;
      first_slot <= '0;
      built <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_ARENA) arena_bytes <= cfg_data;
        else header_bytes <= cfg_data[HDR_W-1:0];
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind <= s_tuser;
            size <= s_tdata[SZ_W-1:0];
            baddr <= s_tdata[SZ_W +: AW];
            r_addr <= '0;
            r_copy <= '0;
            r_status <= ST_OK;
            cur <= '0;
            hit <= NIL;
            if (s_tuser == KIND_RESTART) begin
              if (arena_clip <= (AW + 1)'(header_bytes)) begin
                r_status <= ST_NOSPACE;
                state <= S_OUT;
              end else begin
                hdr_live <= header_bytes;
                in_use <= MAX_BLOCKS'(1);
                is_free <= MAX_BLOCKS'(1);
                first_slot <= '0;
                built <= 1'b1;
                we <= 1'b1;
                wr_idx <= '0;
                wr_data <= {NIL, NIL,
                  SZ_W'(arena_clip - (AW + 1)'(header_bytes)), AW'(0)};
                state <= S_OUT;
              end
            end else if (s_tuser == KIND_ALLOC) begin
              if (s_tdata[SZ_W-1:0] == '0) begin
                r_status <= ST_NOSPACE;
                state <= S_OUT;
              end else begin
                cur <= first_slot;
                state <= S_SCAN;
              end
            end else if (s_tuser == KIND_RESIZE && s_tdata[SZ_W-1:0] == '0) begin
              r_status <= ST_NOSPACE;
              state <= S_OUT;
            end else begin
              state <= S_FIND;
            end
          end
        end
        // address match over every slot, one read per slot
        S_FIND: begin
          step <= 2'd0;
          if (cur == NIL) begin
            if (hit == NIL || (kind == KIND_RESIZE && is_free[hit[IW-1:0]])) begin
              r_status <= ST_UNKNOWN;
              state <= S_OUT;
            end else if (kind == KIND_RELEASE) begin
              rd_idx <= hit[IW-1:0];
              state <= S_REL;
            end else begin
              rd_idx <= hit[IW-1:0];
              rel_slot <= hit;
              state <= S_FINDW; // capture old payload
            end
          end else begin
            rd_idx <= cur[IW-1:0];
            state <= S_FINDW;
          end
        end
        S_FINDW: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else if (cur == NIL) begin
            old_pay <= e_pay;
            hit <= NIL;
            cur <= first_slot;
            state <= S_SCAN;
          end else begin
            if (in_use[cur[IW-1:0]] && cmp_addr == (AW + 1)'(baddr) && hit == NIL)
              hit <= cur;
            cur <= (cur == SW'(MAX_BLOCKS - 1)) ? NIL : cur + SW'(1);
            state <= S_FIND;
          end
        end
        // best-fit walk in address order
        S_SCAN: begin
          step <= 2'd0;
          if (cur == NIL) begin
            if (hit == NIL) begin
              r_status <= ST_NOSPACE;
              state <= S_OUT;
            end else begin
              rd_idx <= hit[IW-1:0];
              state <= S_GRANTW;
            end
          end else begin
            rd_idx <= cur[IW-1:0];
            state <= S_SCANW;
          end
        end
        S_SCANW: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else begin
            if (in_use[cur[IW-1:0]] && is_free[cur[IW-1:0]] &&
                (SZ_W + 2)'(e_pay) >= req &&
                (hit == NIL || e_pay <= best_pay)) begin
              hit <= cur;
              best_pay <= e_pay;
            end
            // before the first restart slot zero stands alone
            cur <= built ? e_nx : NIL;
            state <= S_SCAN;
          end
        end
        S_GRANTW: state <= S_GRANT;
        S_GRANT: begin
          best_off <= e_off;
          best_nx <= e_nx;
          best_pv <= e_pv;
          is_free[hit[IW-1:0]] <= 1'b0;
          r_addr <= AW'(e_off + AW'(hdr_live));
          if ((SZ_W + 2)'(e_pay) > req + (SZ_W + 2)'(hdr_live) && free_slot != NIL) begin
            fsl <= free_slot;
            in_use[free_slot[IW-1:0]] <= 1'b1;
            is_free[free_slot[IW-1:0]] <= 1'b1;
            we <= 1'b1;
            wr_idx <= free_slot[IW-1:0];
            wr_data <= {hit, e_nx, SZ_W'((SZ_W + 2)'(e_pay) - req),
              AW'((SZ_W + 2)'(e_off) + req)};
            state <= S_SPLIT;
          end else begin
            state <= S_LNK;
          end
        end
        S_SPLIT: begin
          we <= 1'b1;
          wr_idx <= hit[IW-1:0];
          wr_data <= {best_pv, fsl, size, best_off};
          if (best_nx != NIL) begin
            rd_idx <= best_nx[IW-1:0];
            state <= S_NXW;
            step <= 2'd0;
          end else begin
            state <= S_LNK;
          end
        end
        S_NXW: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else begin
            we <= 1'b1;
            wr_idx <= best_nx[IW-1:0];
            wr_data <= {fsl, e_nx, e_pay, e_off};
            state <= S_LNK;
          end
        end
        S_LNK: begin
          if (kind == KIND_RESIZE) begin
            r_copy <= (size < old_pay) ? size : old_pay;
            rd_idx <= rel_slot[IW-1:0];
            hit <= rel_slot;
            step <= 2'd0;
            state <= S_REL;
          end else begin
            state <= S_OUT;
          end
        end
        // release: read slot, mark free, merge with neighbors
        S_REL: begin
          if (is_free[hit[IW-1:0]]) begin
            state <= S_OUT;
          end else begin
            is_free[hit[IW-1:0]] <= 1'b1;
            rel_slot <= hit;
            state <= S_RELW;
          end
        end
        S_RELW: begin
          // rd_data holds rel_slot's entry
          rel_off <= e_off;
          rel_pay <= e_pay;
          rel_nx <= e_nx;
          rel_pv <= e_pv;
          state <= S_MERGE;
          step <= 2'd0;
        end
        S_MERGE: begin
          if (step == 2'd0) begin
            if (rel_nx != NIL && is_free[rel_nx[IW-1:0]]) begin
              mdir <= 1'b1;
              other <= rel_nx;
              rd_idx <= rel_nx[IW-1:0];
              step <= 2'd1;
            end else if (rel_pv != NIL && is_free[rel_pv[IW-1:0]]) begin
              mdir <= 1'b0;
              other <= rel_pv;
              rd_idx <= rel_pv[IW-1:0];
              step <= 2'd1;
            end else begin
              state <= S_OUT;
            end
          end else if (step == 2'd1) begin
            step <= 2'd2;
          end else begin
            // e_* is the neighbor entry
            in_use[mdir ? other[IW-1:0] : rel_slot[IW-1:0]] <= 1'b0;
            is_free[mdir ? other[IW-1:0] : rel_slot[IW-1:0]] <= 1'b0;
            if (mdir) begin
              rel_pay <= SZ_W'(rel_pay + e_pay + SZ_W'(hdr_live));
              rel_nx <= e_nx;
              other <= e_nx;   // node whose prev must now point at rel_slot
            end else begin
              rel_pay <= SZ_W'(rel_pay + e_pay + SZ_W'(hdr_live));
              rel_off <= e_off;
              other <= rel_nx; // node whose prev must now point at the prev
              rel_slot <= other;
              rel_pv <= e_pv;
              if (e_pv == NIL && first_slot == rel_slot) first_slot <= other;
            end
            state <= S_MWR;
            step <= 2'd0;
          end
        end
        S_MWR: begin
          if (step == 2'd0) begin
            we <= 1'b1;
            wr_idx <= rel_slot[IW-1:0];
            wr_data <= {rel_pv, rel_nx, rel_pay, rel_off};
            if (other != NIL) begin
              rd_idx <= other[IW-1:0];
              step <= 2'd1;
            end else begin
              state <= S_MERGE;
            end
          end else if (step == 2'd1) begin
            step <= 2'd2;
          end else begin
            we <= 1'b1;
            wr_idx <= other[IW-1:0];
            wr_data <= {rel_slot, e_nx, e_pay, e_off};
            step <= 2'd0;
            state <= S_MERGE;
          end
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> m_tvalid) else $error("result not raised");
  a_free_used: assert property (@(posedge clk) disable iff (rst)
    (is_free & ~in_use) == '0) else $error("free flag on unused slot");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r_status <= ST_UNKNOWN) else $error("bad status");
`endif
endmodule

[bench/best_fit_block_allocator_tb.sv]
// Self-checking testbench for the best-fit block allocator: directed and random streams.
module best_fit_block_allocator_tb;
  import bfba_pkg::*;

  localparam int NSLOT = MAX_BLOCKS_DEF;
  localparam longint unsigned M20 = 64'hFFFFF;
  localparam longint unsigned M21 = 64'h1FFFFF;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic [19:0] addr;
    logic [20:0] copy;
    logic [1:0]  status;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // tdata: request_bytes[20:0], block_address[40:21], zero fill
  logic [47:0] s_tdata = '0;
  // tuser: kind[1:0]
  logic [1:0] s_tuser = KIND_RESTART;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // tdata: address[19:0], copy_bytes[40:20], status[42:41], zero fill
  logic [47:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_ARENA;
  logic [SZ_W-1:0] cfg_data = '0;

  best_fit_block_allocator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Allocator shadow: block table, latched header, pending registers
  // ---------------------------------------------------------------
  longint unsigned blk_ofs [NSLOT];
  longint unsigned blk_pay [NSLOT];
  bit              blk_free[NSLOT];
  bit              blk_used[NSLOT];
  int              blk_next[NSLOT];
  int              blk_prev[NSLOT];
  int              blk_head;
  longint unsigned hdr_live;
  longint unsigned arena_reg;
  longint unsigned hdr_reg;
  bit              table_built;   // a restart has defined slot zero

  grant_t grant_q[$];             // results still owed by the block

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold = 1'b0;
  int n_words = 0;
  int n_checked = 0;
  int n_bad = 0;
  int n_status[3] = '{0, 0, 0};
  int n_resize_ok = 0;
  int cycles = 0;

  function automatic void clear_blk(int s);
    blk_used[s] = 0;
    blk_free[s] = 0;
    blk_next[s] = NSLOT;
    blk_prev[s] = NSLOT;
  endfunction

  function automatic void unlink_blk(int s);
    int n = blk_next[s];
    int p = blk_prev[s];
    if (n < NSLOT) blk_prev[n] = p;
    if (p < NSLOT) blk_next[p] = n;
    else if (blk_head == s) blk_head = n;
    clear_blk(s);
  endfunction

  function automatic void wipe_table();
    for (int s = 0; s < NSLOT; s++) begin
      blk_ofs[s] = 0;
      blk_pay[s] = 0;
      clear_blk(s);
    end
    blk_used[0] = 1;
    blk_head = 0;
  endfunction

  function automatic int find_blk(longint unsigned addr);
    for (int s = 0; s < NSLOT; s++)
      if (blk_used[s] && blk_ofs[s] + hdr_live == addr) return s;
    return NSLOT;
  endfunction

  // best fit, last in address order on a tie; split when worth it and a slot is spare
  function automatic bit take_block(longint unsigned size, output longint unsigned addr);
    longint unsigned need = size + hdr_live;
    int best = NSLOT;
    int s = blk_head;
    int f;
    addr = 0;
    if (size == 0) return 0;
    for (int n = 0; n < NSLOT && s < NSLOT; n++) begin
      if (blk_used[s] && blk_free[s] && blk_pay[s] >= need)
        if (best == NSLOT || blk_pay[s] <= blk_pay[best]) best = s;
      s = blk_next[s];
    end
    if (best == NSLOT) return 0;
    if (blk_pay[best] > need + hdr_live) begin
      for (f = 0; f < NSLOT && blk_used[f]; f++) ;
      if (f < NSLOT) begin
        blk_ofs[f]  = (blk_ofs[best] + need) & 64'hFFFFFFFF;
        blk_pay[f]  = (blk_pay[best] - need) & M21;
        blk_free[f] = 1;
        blk_used[f] = 1;
        blk_next[f] = blk_next[best];
        blk_prev[f] = best;
        if (blk_next[best] < NSLOT) blk_prev[blk_next[best]] = f;
        blk_next[best] = f;
        blk_pay[best] = size & M21;
      end
    end
    blk_free[best] = 0;
    addr = blk_ofs[best] + hdr_live;
    return 1;
  endfunction

  function automatic void free_and_merge(int s);
    int nx, pv;
    if (blk_free[s]) return;
    blk_free[s] = 1;
    for (int n = 0; n < 2 * NSLOT; n++) begin
      nx = blk_next[s];
      pv = blk_prev[s];
      if (nx < NSLOT && blk_free[nx]) begin
        blk_pay[s] = (blk_pay[s] + blk_pay[nx] + hdr_live) & M21;
        unlink_blk(nx);
      end else if (pv < NSLOT && blk_free[pv]) begin
        blk_pay[pv] = (blk_pay[pv] + blk_pay[s] + hdr_live) & M21;
        unlink_blk(s);
        s = pv;
      end else begin
        break;
      end
    end
  endfunction

  // advance the shadow by one accepted word and return the owed result
  function automatic grant_t apply_word(logic [1:0] kind, longint unsigned size,
                                        longint unsigned baddr);
    grant_t r = '0;
    longint unsigned addr = 0, copy = 0, arena;
    int s;
    case (kind)
      KIND_RESTART: begin
        arena = (arena_reg > (64'd1 << ADDR_BITS_DEF)) ? (64'd1 << ADDR_BITS_DEF) : arena_reg;
        if (arena <= hdr_reg) begin
          r.status = ST_NOSPACE;
        end else begin
          wipe_table();
          hdr_live = hdr_reg;
          blk_free[0] = 1;
          blk_pay[0] = (arena - hdr_live) & M21;
          table_built = 1;
        end
      end
      KIND_ALLOC: begin
        if (!take_block(size, addr)) begin
          addr = 0;
          r.status = ST_NOSPACE;
        end
      end
      KIND_RELEASE: begin
        s = find_blk(baddr);
        if (s == NSLOT) r.status = ST_UNKNOWN;
        else free_and_merge(s);
      end
      default: begin
        s = find_blk(baddr);
        if (size == 0) r.status = ST_NOSPACE;
        else if (s == NSLOT || blk_free[s]) r.status = ST_UNKNOWN;
        else if (!take_block(size, addr)) begin
          addr = 0;
          r.status = ST_NOSPACE;
        end else begin
          copy = (size < blk_pay[s]) ? size : blk_pay[s];
          free_and_merge(s);
        end
      end
    endcase
    r.addr = addr & M20;
    r.copy = copy & M21;
    return r;
  endfunction

  // payload address of a random live block with the given free mark, else a random one
  function automatic longint unsigned pick_block(bit want_free);
    int hits[$];
    for (int s = 0; s < NSLOT; s++)
      if (blk_used[s] && blk_free[s] == want_free) hits.push_back(s);
    if (!table_built || hits.size() == 0) return $urandom_range(1048575);
    return (blk_ofs[hits[$urandom_range(hits.size() - 1)]] + hdr_live) & M20;
  endfunction

  // ---------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------
  task automatic send_word(input logic [1:0] kind, input longint unsigned size,
                           input longint unsigned baddr, output grant_t r);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, baddr[19:0], size[20:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_word(kind, size, baddr);
    grant_q.push_back(r);
    n_words++;
  endtask

  task automatic go_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // registers are written with the block idle; they matter at the next restart
  task automatic write_reg(input logic idx, input longint unsigned value);
    go_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[SZ_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ARENA) arena_reg = value & M21;
    else hdr_reg = value & 64'h7F;
  endtask

  // random request size: mostly small so the table fills, now and then wide
  function automatic longint unsigned rand_size();
    int pick = $urandom_range(99);
    if (pick < 3) return 0;
    if (pick < 8) return $urandom_range(1048576);
    if (pick < 15) return $urandom_range(20000, 1);
    return $urandom_range(900, 1);
  endfunction

  task automatic random_word();
    grant_t r;
    int pick = $urandom_range(99);
    longint unsigned baddr;
    if (pick < 4 || !table_built) begin
      send_word(KIND_RESTART, rand_size(), $urandom_range(1048575), r);
    end else if (pick < 50) begin
      send_word(KIND_ALLOC, rand_size(), $urandom_range(1048575), r);
    end else begin
      pick = $urandom_range(99);
      if (pick < 75) baddr = pick_block(0);
      else if (pick < 87) baddr = pick_block(1);
      else baddr = $urandom_range(1048575);
      send_word(($urandom_range(99) < 60) ? KIND_RELEASE : KIND_RESIZE, rand_size(), baddr, r);
    end
  endtask

  // ---------------------------------------------------------------
  // Receive side and checking
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !rx_hold && (rx_idle_pct == 0 || $urandom_range(99) >= rx_idle_pct);
  end

  function automatic void flag_bad(string what, grant_t want, grant_t got);
    n_bad++;
    if (n_bad <= 10)
      $display("mismatch %s: want addr=%h copy=%h status=%0d got addr=%h copy=%h status=%0d",
               what, want.addr, want.copy, want.status, got.addr, got.copy, got.status);
  endfunction

  always @(posedge clk) begin
    grant_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.addr   = m_tdata[19:0];
      got.copy   = m_tdata[40:20];
      got.status = m_tdata[42:41];
      if (grant_q.size() == 0) begin
        flag_bad("unexpected word", '0, got);
      end else begin
        want = grant_q.pop_front();
        n_checked++;
        if (want.status <= ST_UNKNOWN) n_status[want.status]++;
        if (want.copy != 0) n_resize_ok++;
        if (got.addr != want.addr) flag_bad("address", want, got);
        if (got.copy != want.copy) flag_bad("copy_bytes", want, got);
        if (got.status != want.status) flag_bad("status", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words owed", cycles, grant_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    grant_t r, a, b;
    // allocate before any restart: slot zero is taken, nothing free
    send_word(KIND_ALLOC, 16, 0, r);
    send_word(KIND_RESTART, 0, 0, r);
    send_word(KIND_ALLOC, 0, 0, r);               // zero size
    send_word(KIND_ALLOC, 1048576, 0, r);         // no space
    send_word(KIND_ALLOC, 100, 0, a);
    send_word(KIND_ALLOC, 1, 0, b);
    send_word(KIND_RESIZE, 0, a.addr, r);         // zero resize
    send_word(KIND_RELEASE, 0, 20'hFFFFF, r);     // unknown address
    send_word(KIND_RESIZE, 50, 20'h00005, r);     // unknown resize
    send_word(KIND_RESIZE, 300, a.addr, a);       // grow, copy old size
    send_word(KIND_RESIZE, 10, a.addr, a);        // shrink, copy request
    send_word(KIND_RELEASE, 0, b.addr, r);
    send_word(KIND_RELEASE, 0, b.addr, r);        // already free
    send_word(KIND_RESIZE, 10, b.addr, r);        // resize of a free block
    send_word(KIND_ALLOC, 65536 - 200, 0, r);     // takes the big tail, splitting off a small rest
    send_word(KIND_RELEASE, 0, a.addr, r);
  endtask

  task automatic test_config_extremes();
    grant_t r;
    write_reg(REG_ARENA, 40);                     // arena equals header: rejected
    send_word(KIND_RESTART, 0, 0, r);
    write_reg(REG_ARENA, 0);
    send_word(KIND_RESTART, 0, 0, r);
    write_reg(REG_ARENA, 1048576);                // full address space
    write_reg(REG_HEADER, 64);
    send_word(KIND_RESTART, 0, 0, r);
    send_word(KIND_ALLOC, 1048576 - 128, 0, r);   // exactly fits without split
    write_reg(REG_HEADER, 1);
    write_reg(REG_ARENA, 3);
    send_word(KIND_RESTART, 0, 0, r);
    send_word(KIND_ALLOC, 1, 0, r);               // two-byte arena payload
    send_word(KIND_ALLOC, 1, 0, r);
  endtask

  task automatic test_random(input longint unsigned arena, input longint unsigned hdr,
                             input int tx_pct, input int rx_pct, input int count);
    grant_t r;
    write_reg(REG_ARENA, arena);
    write_reg(REG_HEADER, hdr);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    send_word(KIND_RESTART, 0, 0, r);
    repeat (count) random_word();
    go_quiet();
  endtask

  // receiver stalls for a long stretch while words keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (12) random_word();
    go_quiet();
  endtask

  initial begin
    hdr_live = 40;
    arena_reg = 65536;
    hdr_reg = 40;
    table_built = 0;
    wipe_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random(65536, 40, 36, 80, 330);
    test_random(4096, 1, 80, 36, 330);
    test_backpressure();
    test_random(1048576, 64, 0, 0, 330);

    go_quiet();
    repeat (20) @(posedge clk);
    $display("covered %0d words over several arena/header settings, %0d results checked",
             n_words, n_checked);
    $display("status ok/nospace/unknown: %0d/%0d/%0d, resizes with copy: %0d, mismatches: %0d",
             n_status[0], n_status[1], n_status[2], n_resize_ok, n_bad);
    if (n_bad == 0 && grant_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
